FILE: sv/token_scanner_assert.svh
`ifndef TOKEN_SCANNER_ASSERT_SVH
`define TOKEN_SCANNER_ASSERT_SVH

// Implication checked in the same cycle
`define TS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("token_scanner check failed");

// Implication checked in the next cycle
`define TS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("token_scanner check failed");

`endif

FILE: sv/tsc_pkg.sv
package tsc_pkg;

    typedef enum logic [3:0] {
        ST_IDLE = 4'd0,
        ST_WS   = 4'd1,
        ST_CR   = 4'd2,
        ST_STR  = 4'd3,
        ST_ESC  = 4'd4,
        ST_NAME = 4'd5,
        ST_INT  = 4'd6,
        ST_FRAC = 4'd7,
        ST_EXPE = 4'd8,
        ST_EXPS = 4'd9,
        ST_EXPD = 4'd10,
        ST_ERR  = 4'd11
    } lex_state_t;

    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_END   = 2'd1,
        EV_ERROR = 2'd2
    } ev_t;

    typedef enum logic [2:0] {
        TT_EOI    = 3'd0,
        TT_WS     = 3'd1,
        TT_LT     = 3'd2,
        TT_ASSIGN = 3'd3,
        TT_STRING = 3'd4,
        TT_NAME   = 3'd5,
        TT_NUMBER = 3'd6
    } tt_t;

    localparam int CP_W = 21;

    localparam logic [CP_W-1:0] CH_TAB    = 21'h09;
    localparam logic [CP_W-1:0] CH_LF     = 21'h0A;
    localparam logic [CP_W-1:0] CH_CR     = 21'h0D;
    localparam logic [CP_W-1:0] CH_SPACE  = 21'h20;
    localparam logic [CP_W-1:0] CH_QUOTE  = 21'h22;
    localparam logic [CP_W-1:0] CH_PLUS   = 21'h2B;
    localparam logic [CP_W-1:0] CH_MINUS  = 21'h2D;
    localparam logic [CP_W-1:0] CH_DOT    = 21'h2E;
    localparam logic [CP_W-1:0] CH_ASSIGN = 21'h3D;
    localparam logic [CP_W-1:0] CH_BSLASH = 21'h5C;
    localparam logic [CP_W-1:0] CH_UNDER  = 21'h5F;
    localparam logic [CP_W-1:0] CH_UP_E   = 21'h45;
    localparam logic [CP_W-1:0] CH_LO_E   = 21'h65;
    localparam logic [CP_W-1:0] CH_LO_N   = 21'h6E;
    localparam logic [CP_W-1:0] CH_LO_R   = 21'h72;

    typedef struct packed {
        ev_t             ev;
        tt_t             tt;
        logic [CP_W-1:0] ch;
        logic            last;
    } res_t;

    typedef struct packed {
        lex_state_t nxt;
        logic [1:0] cnt;
        res_t       r0;
        res_t       r1;
    } step_t;

    function automatic res_t mk_res(input ev_t ev, input tt_t tt, input logic [CP_W-1:0] ch);
        res_t r;
        r.ev   = ev;
        r.tt   = tt;
        r.ch   = ch;
        r.last = 1'b0;
        return r;
    endfunction

endpackage

FILE: sv/token_scanner.sv
// A request is registered on acceptance and scanned from that register; it is consumed
// once the result queue has room, and its results are offered from the queue head.
// Throughput: one request per cycle while the four-entry result queue has room for two;
// results leave it one per cycle while m_ready is high, so two-result requests go at the drain rate.
// Reset clears the scanner to the start state and empties the input and result stages.
module token_scanner (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_kind,
    input  logic [20:0] s_code_point,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_event_res,
    output logic [2:0]  m_token_type,
    output logic [20:0] m_char_value,
    output logic        m_last
);

    logic                      in_valid_reg;
    logic                      kind_reg;
    logic [tsc_pkg::CP_W-1:0]  cp_reg;
    tsc_pkg::lex_state_t       state_reg;
    tsc_pkg::step_t            step;
    tsc_pkg::res_t             r0;
    tsc_pkg::res_t             r1;
    tsc_pkg::res_t             head;
    logic [2:0]                q_count;
    logic                      push;
    logic [1:0]                push_cnt;
    logic                      pop;

    // Room for two results must be there before a request is scanned
    assign push     = in_valid_reg && (q_count < 3'd3);
    assign push_cnt = push ? step.cnt : 2'd0;
    assign s_ready  = !in_valid_reg || push;
    assign pop      = m_valid && m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            state_reg    <= tsc_pkg::ST_IDLE;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (push) begin
                state_reg <= step.nxt;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            kind_reg <= s_kind;
            cp_reg   <= s_code_point;
        end
    end

    tsc_step u_step (
        .state      (state_reg),
        .kind       (kind_reg),
        .code_point (cp_reg),
        .step       (step)
    );

    // Mark the final result of this request
    always_comb begin
        r0      = step.r0;
        r1      = step.r1;
        r0.last = (step.cnt == 2'd1);
        r1.last = 1'b1;
    end

    tsc_resq u_resq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push_cnt (push_cnt),
        .push_r0  (r0),
        .push_r1  (r1),
        .pop      (pop),
        .head     (head),
        .count    (q_count)
    );

    assign m_valid      = (q_count != 3'd0);
    assign m_event_res  = head.ev;
    assign m_token_type = head.tt;
    assign m_char_value = head.ch;
    assign m_last       = head.last;

endmodule

FILE: sv/tsc_step.sv
module tsc_step (
    input  tsc_pkg::lex_state_t       state,
    input  logic                      kind,
    input  logic [tsc_pkg::CP_W-1:0]  code_point,
    output tsc_pkg::step_t            step
);

    function automatic logic is_digit(input logic [tsc_pkg::CP_W-1:0] c);
        return c >= 21'h30 && c <= 21'h39;
    endfunction

    function automatic logic is_alpha(input logic [tsc_pkg::CP_W-1:0] c);
        return (c >= 21'h41 && c <= 21'h5A) || (c >= 21'h61 && c <= 21'h7A);
    endfunction

    logic                      rescan;
    logic                      pend_vld;
    tsc_pkg::tt_t              pend_tt;
    logic                      st_has;
    tsc_pkg::res_t             st_res;
    tsc_pkg::lex_state_t       st_nxt;
    tsc_pkg::res_t             err_res;

    assign err_res  = tsc_pkg::mk_res(tsc_pkg::EV_ERROR, tsc_pkg::TT_EOI, '0);

    // Scan the symbol as the first one of a new token
    always_comb begin
        st_has = 1'b1;
        st_res = err_res;
        st_nxt = tsc_pkg::ST_IDLE;
        priority if (code_point == tsc_pkg::CH_SPACE || code_point == tsc_pkg::CH_TAB) begin
            st_has = 1'b0;
            st_nxt = tsc_pkg::ST_WS;
        end else if (code_point == tsc_pkg::CH_CR) begin
            st_has = 1'b0;
            st_nxt = tsc_pkg::ST_CR;
        end else if (code_point == tsc_pkg::CH_LF) begin
            st_res = tsc_pkg::mk_res(tsc_pkg::EV_END, tsc_pkg::TT_LT, '0);
        end else if (code_point == tsc_pkg::CH_ASSIGN) begin
            st_res = tsc_pkg::mk_res(tsc_pkg::EV_END, tsc_pkg::TT_ASSIGN, '0);
        end else if (code_point == tsc_pkg::CH_QUOTE) begin
            st_has = 1'b0;
            st_nxt = tsc_pkg::ST_STR;
        end else if (code_point == tsc_pkg::CH_UNDER || is_alpha(code_point)) begin
            st_res = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NAME, code_point);
            st_nxt = tsc_pkg::ST_NAME;
        end else if (is_digit(code_point)) begin
            st_res = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NUMBER, code_point);
            st_nxt = tsc_pkg::ST_INT;
        end else begin
            st_nxt = tsc_pkg::ST_ERR;
        end
    end

    always_comb begin
        rescan   = 1'b0;
        pend_vld = 1'b0;
        pend_tt  = tsc_pkg::TT_EOI;
        step.nxt = state;
        step.cnt = 2'd0;
        step.r0  = err_res;
        step.r1  = err_res;

        if (state == tsc_pkg::ST_ERR) begin
            step.cnt = 2'd1;
        end else if (kind) begin
            unique case (state)
                tsc_pkg::ST_WS: begin
                    pend_vld = 1'b1;
                    pend_tt  = tsc_pkg::TT_WS;
                end
                tsc_pkg::ST_CR: begin
                    pend_vld = 1'b1;
                    pend_tt  = tsc_pkg::TT_LT;
                end
                tsc_pkg::ST_NAME: begin
                    pend_vld = 1'b1;
                    pend_tt  = tsc_pkg::TT_NAME;
                end
                tsc_pkg::ST_INT, tsc_pkg::ST_FRAC, tsc_pkg::ST_EXPD: begin
                    pend_vld = 1'b1;
                    pend_tt  = tsc_pkg::TT_NUMBER;
                end
                default: ;
            endcase
            if (state == tsc_pkg::ST_STR || state == tsc_pkg::ST_ESC ||
                state == tsc_pkg::ST_EXPE || state == tsc_pkg::ST_EXPS) begin
                step.cnt = 2'd1;
                step.nxt = tsc_pkg::ST_ERR;
            end else begin
                step.nxt = tsc_pkg::ST_IDLE;
                if (pend_vld) begin
                    step.cnt = 2'd2;
                    step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_END, pend_tt, '0);
                    step.r1  = tsc_pkg::mk_res(tsc_pkg::EV_END, tsc_pkg::TT_EOI, '0);
                end else begin
                    step.cnt = 2'd1;
                    step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_END, tsc_pkg::TT_EOI, '0);
                end
            end
        end else begin
            unique case (state)
                tsc_pkg::ST_IDLE: rescan = 1'b1;
                tsc_pkg::ST_WS: begin
                    if (code_point != tsc_pkg::CH_SPACE && code_point != tsc_pkg::CH_TAB) begin
                        pend_vld = 1'b1;
                        pend_tt  = tsc_pkg::TT_WS;
                        rescan   = 1'b1;
                    end
                end
                tsc_pkg::ST_CR: begin
                    if (code_point == tsc_pkg::CH_LF) begin
                        step.cnt = 2'd1;
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_END, tsc_pkg::TT_LT, '0);
                        step.nxt = tsc_pkg::ST_IDLE;
                    end else begin
                        pend_vld = 1'b1;
                        pend_tt  = tsc_pkg::TT_LT;
                        rescan   = 1'b1;
                    end
                end
                tsc_pkg::ST_STR: begin
                    if (code_point == tsc_pkg::CH_BSLASH) begin
                        step.nxt = tsc_pkg::ST_ESC;
                    end else if (code_point == tsc_pkg::CH_QUOTE) begin
                        step.cnt = 2'd1;
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_END, tsc_pkg::TT_STRING, '0);
                        step.nxt = tsc_pkg::ST_IDLE;
                    end else begin
                        step.cnt = 2'd1;
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_STRING,
                                                   code_point);
                    end
                end
                tsc_pkg::ST_ESC: begin
                    // Valid escape returns to the string body after one character
                    step.cnt = 2'd1;
                    step.nxt = tsc_pkg::ST_STR;
                    priority if (code_point == tsc_pkg::CH_QUOTE ||
                                 code_point == tsc_pkg::CH_BSLASH) begin
                        step.r0 = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_STRING,
                                                  code_point);
                    end else if (code_point == tsc_pkg::CH_LO_N) begin
                        step.r0 = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_STRING,
                                                  tsc_pkg::CH_LF);
                    end else if (code_point == tsc_pkg::CH_LO_R) begin
                        step.r0 = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_STRING,
                                                  tsc_pkg::CH_CR);
                    end else begin
                        step.nxt = tsc_pkg::ST_ERR;
                    end
                end
                tsc_pkg::ST_NAME: begin
                    if (code_point == tsc_pkg::CH_UNDER || is_alpha(code_point) ||
                        is_digit(code_point)) begin
                        step.cnt = 2'd1;
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NAME,
                                                   code_point);
                    end else begin
                        pend_vld = 1'b1;
                        pend_tt  = tsc_pkg::TT_NAME;
                        rescan   = 1'b1;
                    end
                end
                tsc_pkg::ST_INT, tsc_pkg::ST_FRAC, tsc_pkg::ST_EXPD: begin
                    if (is_digit(code_point)) begin
                        step.cnt = 2'd1;
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NUMBER,
                                                   code_point);
                    end else if (state == tsc_pkg::ST_INT &&
                                 code_point == tsc_pkg::CH_DOT) begin
                        step.cnt = 2'd1;
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NUMBER,
                                                   code_point);
                        step.nxt = tsc_pkg::ST_FRAC;
                    end else if (state == tsc_pkg::ST_FRAC &&
                                 (code_point == tsc_pkg::CH_LO_E ||
                                  code_point == tsc_pkg::CH_UP_E)) begin
                        step.cnt = 2'd1;
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NUMBER,
                                                   code_point);
                        step.nxt = tsc_pkg::ST_EXPE;
                    end else begin
                        pend_vld = 1'b1;
                        pend_tt  = tsc_pkg::TT_NUMBER;
                        rescan   = 1'b1;
                    end
                end
                tsc_pkg::ST_EXPE, tsc_pkg::ST_EXPS: begin
                    step.cnt = 2'd1;
                    if (is_digit(code_point)) begin
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NUMBER,
                                                   code_point);
                        step.nxt = tsc_pkg::ST_EXPD;
                    end else if (state == tsc_pkg::ST_EXPE &&
                                 (code_point == tsc_pkg::CH_PLUS ||
                                  code_point == tsc_pkg::CH_MINUS)) begin
                        step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_CHAR, tsc_pkg::TT_NUMBER,
                                                   code_point);
                        step.nxt = tsc_pkg::ST_EXPS;
                    end else begin
                        step.nxt = tsc_pkg::ST_ERR;
                    end
                end
                default: begin
                    step.cnt = 2'd1;
                    step.nxt = tsc_pkg::ST_ERR;
                end
            endcase

            if (rescan) begin
                step.nxt = st_nxt;
                if (pend_vld) begin
                    step.r0  = tsc_pkg::mk_res(tsc_pkg::EV_END, pend_tt, '0);
                    step.r1  = st_res;
                    step.cnt = st_has ? 2'd2 : 2'd1;
                end else begin
                    step.r0  = st_res;
                    step.cnt = st_has ? 2'd1 : 2'd0;
                end
            end
        end
    end

endmodule

FILE: sv/tsc_resq.sv
module tsc_resq (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic [1:0]    push_cnt,
    input  tsc_pkg::res_t push_r0,
    input  tsc_pkg::res_t push_r1,
    input  logic          pop,
    output tsc_pkg::res_t head,
    output logic [2:0]    count
);

    tsc_pkg::res_t mem [0:3];
    logic [1:0]    wr_reg;
    logic [1:0]    rd_reg;
    logic [2:0]    cnt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= 2'd0;
            rd_reg  <= 2'd0;
            cnt_reg <= 3'd0;
        end else begin
            wr_reg  <= wr_reg + push_cnt;
            rd_reg  <= rd_reg + {1'b0, pop};
            cnt_reg <= cnt_reg + {1'b0, push_cnt} - {2'b00, pop};
        end
    end

    always_ff @(posedge aclk) begin
        if (push_cnt != 2'd0) begin
            mem[wr_reg] <= push_r0;
        end
        if (push_cnt == 2'd2) begin
            mem[wr_reg + 2'd1] <= push_r1;
        end
    end

    assign head  = mem[rd_reg];
    assign count = cnt_reg;

endmodule

FILE: sv/tsc_check.sv
`include "token_scanner_assert.svh"

module tsc_check (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        s_kind,
    input logic [20:0] s_code_point,
    input logic        m_valid,
    input logic        m_ready,
    input logic [1:0]  m_event_res,
    input logic [2:0]  m_token_type,
    input logic [20:0] m_char_value,
    input logic        m_last
);

    // A stalled result holds its event and character value
    `TS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_char_value) && $stable(m_event_res))

    // Error sticks: nothing but errors follow an error
    `TS_ASSERT_NEXT(a_err_sticky, m_valid && m_ready && m_event_res == tsc_pkg::EV_ERROR, !m_valid || m_event_res == tsc_pkg::EV_ERROR)

    // An error closes its request and carries no token type
    `TS_ASSERT_NOW(a_err_form, m_valid && m_event_res == tsc_pkg::EV_ERROR, m_last && m_token_type == tsc_pkg::TT_EOI)

    // Only text characters carry a code point
    `TS_ASSERT_NOW(a_char_zero, m_valid && m_event_res != tsc_pkg::EV_CHAR, m_char_value == 21'd0)

endmodule

bind token_scanner tsc_check u_tsc_check (.*);
